@@ rtl/nqcd_pkg.sv @@
`default_nettype none

package nqcd_pkg;

  localparam int DEF_MAX_VARS = 32;
  localparam int VALUE_W      = 32;
  localparam int GRAD_W       = 48;
  localparam int PROD_W       = 65;
  localparam int NUM_W        = 64;
  localparam int QMAG_W       = 34;
  localparam int NX_W         = 36;
  localparam int DX_W         = 33;

  // Quotient magnitude limit: four times the largest solution value.
  localparam logic [QMAG_W-1:0] QLIM = QMAG_W'(64'd4 * 64'd2147483647);
  localparam logic signed [NX_W-1:0] XMAX = NX_W'(64'd2147483647);

  localparam logic CFG_SIZE   = 1'b0;
  localparam logic CFG_SWEEPS = 1'b1;

  typedef enum logic [1:0] {
    KIND_MATRIX = 2'd0,
    KIND_LINEAR = 2'd1,
    KIND_START  = 2'd2,
    KIND_SOLVE  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                      kind;
    logic [4:0]                 row;
    logic [4:0]                 col;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]                 index;
    logic signed [VALUE_W-1:0]  solution;
    logic                       last;
  } out_item_t;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_I_RD  = 14'b00000000000010,
    ST_I_MUL = 14'b00000000000100,
    ST_I_ACC = 14'b00000000001000,
    ST_S_RD  = 14'b00000000010000,
    ST_S_CHK = 14'b00000000100000,
    ST_DIV   = 14'b00000001000000,
    ST_STEP  = 14'b00000010000000,
    ST_U_RD  = 14'b00000100000000,
    ST_U_MUL = 14'b00001000000000,
    ST_U_ACC = 14'b00010000000000,
    ST_E_RD  = 14'b00100000000000,
    ST_E_OUT = 14'b01000000000000,
    ST_E_WAIT = 14'b10000000000000
  } state_e;

  // Product shifted right by 16, rounding toward minus infinity.
  function automatic logic signed [GRAD_W:0] floor_q16(input logic signed [PROD_W-1:0] p);
    return p[PROD_W-1:16];
  endfunction

  // Saturate a sum to the signed gradient range.
  function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [GRAD_W+1:0] v);
    logic signed [GRAD_W-1:0] r;
    if ((v[GRAD_W+1:GRAD_W-1] == 3'b000) || (v[GRAD_W+1:GRAD_W-1] == 3'b111)) begin
      r = v[GRAD_W-1:0];
    end else if (v[GRAD_W+1]) begin
      r = {1'b1, {(GRAD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(GRAD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/nonneg_quadratic_coord_descent.sv @@
`default_nettype none

// Nonnegative quadratic program solver, cyclic coordinate descent.
// Input channel (in_valid_i, in_stall_o, in_item_i): load transactions write
// one matrix entry, one linear term or one start value and are taken one per
// cycle while the block is idle. A solve transaction forms the gradient H*x+h
// and runs the configured number of sweeps, each a projected Newton step per
// coordinate with a positive diagonal. in_stall_o stays high until the last
// solution element has been taken.
// Output channel (out_valid_o, out_stall_i, out_item_o): one transaction per
// solution element in index order, last set on the final one. A stalled
// element holds in the output register until taken.
// A solve with n variables and S sweeps first forms the gradient over all n*n
// matrix entries, then per sweep and coordinate does a lookup, runs the
// bit-serial divider, takes a step and updates the gradient over n entries,
// then emits each element through read, output and wait states plus stall
// time. The divider and the single read port of the matrix memory set the pace.
// Reset clears the control state, sets size_q to 32 and sweeps_q to 1; the
// memories are not cleared and must be loaded before a solve.
module nonneg_quadratic_coord_descent #(
  parameter int MAX_VARS = nqcd_pkg::DEF_MAX_VARS
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  nqcd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output nqcd_pkg::out_item_t out_item_o,
  input  wire                 cfg_we_i,
  input  wire                 cfg_index_i,
  input  wire  [15:0]         cfg_data_i
);
  import nqcd_pkg::*;

  localparam int IDX_W = $clog2(MAX_VARS);
  localparam int AW    = $clog2(MAX_VARS * MAX_VARS);
  localparam int DEPTH = MAX_VARS * MAX_VARS;

  function automatic logic [AW-1:0] mat_addr(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
    return AW'(r) * AW'(MAX_VARS) + AW'(c);
  endfunction

  // Memories: one write and one registered read port each.
  logic signed [VALUE_W-1:0] mat_mem  [DEPTH];
  logic signed [VALUE_W-1:0] lin_mem  [MAX_VARS];
  logic signed [VALUE_W-1:0] sol_mem  [MAX_VARS];
  logic signed [GRAD_W-1:0]  grad_mem [MAX_VARS];

  logic                      mat_we, lin_we, sol_we, grad_we;
  logic [AW-1:0]             mat_wa, mat_ra;
  logic [IDX_W-1:0]          lin_wa, lin_ra, sol_wa, sol_ra, grad_wa, grad_ra;
  logic signed [VALUE_W-1:0] mat_wd, lin_wd, sol_wd;
  logic signed [GRAD_W-1:0]  grad_wd;
  logic signed [VALUE_W-1:0] mat_rd, lin_rd, sol_rd;
  logic signed [GRAD_W-1:0]  grad_rd;

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[mat_wa] <= mat_wd;
    end
    mat_rd <= mat_mem[mat_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lin_we) begin
      lin_mem[lin_wa] <= lin_wd;
    end
    lin_rd <= lin_mem[lin_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sol_we) begin
      sol_mem[sol_wa] <= sol_wd;
    end
    sol_rd <= sol_mem[sol_ra];
  end

  always_ff @(posedge clk_i) begin
    if (grad_we) begin
      grad_mem[grad_wa] <= grad_wd;
    end
    grad_rd <= grad_mem[grad_ra];
  end

  // Control state.
  state_e           state_q, state_d;
  logic [IDX_W-1:0] a_q, a_d, b_q, b_d;
  logic [15:0]      sw_q, sw_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [5:0]       size_q;
  logic [15:0]      sweeps_q;

  // Datapath registers.
  logic signed [GRAD_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [VALUE_W-1:0] x_q, x_d;
  logic [VALUE_W-2:0]        div_q, div_d;
  logic                      neg_q, neg_d;
  logic [NUM_W-1:0]          num_q, num_d, quo_q, quo_d;
  logic [VALUE_W-1:0]        rem_q, rem_d;
  logic signed [DX_W-1:0]    dx_q, dx_d;
  out_item_t                 out_q, out_d;

  logic [6:0]       lim;
  logic [IDX_W-1:0] last_idx;
  logic             row_ok, col_ok, in_acc, out_acc;

  logic signed [NUM_W-1:0]  num_s;
  logic [VALUE_W:0]         rem_sh;
  logic                     qbit;
  logic [QMAG_W-1:0]        qc;
  logic signed [NX_W-1:0]   qs, nx_full, nx;
  logic signed [GRAD_W+1:0] sum;

  always_comb begin
    if (size_q == 6'd0) begin
      lim = 7'd1;
    end else if (7'(size_q) > 7'(MAX_VARS)) begin
      lim = 7'(MAX_VARS);
    end else begin
      lim = 7'(size_q);
    end
    last_idx = IDX_W'(lim - 7'd1);
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign row_ok      = 32'(in_item_i.row) < MAX_VARS;
  assign col_ok      = 32'(in_item_i.col) < MAX_VARS;

  // Divider step: restoring, one quotient bit per cycle.
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign qbit   = rem_sh >= {2'b00, div_q};

  // Step: clamp the quotient, then the new solution value.
  always_comb begin
    qc      = (quo_q > NUM_W'(QLIM)) ? QLIM : QMAG_W'(quo_q);
    qs      = neg_q ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
    nx_full = NX_W'(x_q) - qs;
    if (nx_full < 0) begin
      nx = '0;
    end else if (nx_full > XMAX) begin
      nx = XMAX;
    end else begin
      nx = nx_full;
    end
  end

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    sw_d        = sw_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    x_d         = x_q;
    div_d       = div_q;
    neg_d       = neg_q;
    num_d       = num_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dx_d        = dx_q;
    out_d       = out_q;
    num_s       = '0;
    sum         = '0;

    mat_we  = 1'b0;
    lin_we  = 1'b0;
    sol_we  = 1'b0;
    grad_we = 1'b0;
    mat_wa  = mat_addr(IDX_W'(in_item_i.row), IDX_W'(in_item_i.col));
    lin_wa  = IDX_W'(in_item_i.row);
    sol_wa  = IDX_W'(in_item_i.row);
    grad_wa = b_q;
    mat_wd  = in_item_i.value;
    lin_wd  = in_item_i.value;
    sol_wd  = in_item_i.value;
    grad_wd = acc_q;
    mat_ra  = mat_addr(a_q, b_q);
    lin_ra  = a_q;
    sol_ra  = b_q;
    grad_ra = b_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item_i.kind)
            KIND_MATRIX: mat_we = row_ok && col_ok;
            KIND_LINEAR: lin_we = row_ok;
            KIND_START:  sol_we = row_ok;
            KIND_SOLVE: begin
              a_d     = '0;
              b_d     = '0;
              state_d = ST_I_RD;
            end
            default: ;
          endcase
        end
      end
      ST_I_RD: begin
        state_d = ST_I_MUL;
      end
      ST_I_MUL: begin
        prod_d = PROD_W'(mat_rd) * PROD_W'(sol_rd);
        if (b_q == '0) begin
          acc_d = GRAD_W'(lin_rd);
        end
        state_d = ST_I_ACC;
      end
      ST_I_ACC: begin
        sum     = (GRAD_W+2)'(acc_q) + (GRAD_W+2)'(floor_q16(prod_q));
        acc_d   = sat_grad(sum);
        grad_wa = a_q;
        grad_wd = sat_grad(sum);
        if (b_q == last_idx) begin
          grad_we = 1'b1;
          b_d     = '0;
          if (a_q == last_idx) begin
            a_d     = '0;
            sw_d    = '0;
            state_d = (sweeps_q == '0) ? ST_E_RD : ST_S_RD;
          end else begin
            a_d     = a_q + 1'b1;
            state_d = ST_I_RD;
          end
        end else begin
          b_d     = b_q + 1'b1;
          state_d = ST_I_RD;
        end
      end
      ST_S_RD: begin
        mat_ra  = mat_addr(a_q, a_q);
        grad_ra = a_q;
        sol_ra  = a_q;
        state_d = ST_S_CHK;
      end
      ST_S_CHK: begin
        x_d   = sol_rd;
        div_d = mat_rd[VALUE_W-2:0];
        neg_d = grad_rd[GRAD_W-1];
        num_s = {grad_rd, 16'h0000};
        num_d = neg_d ? NUM_W'(-num_s) : NUM_W'(num_s);
        rem_d = '0;
        quo_d = '0;
        cnt_d = '0;
        if (mat_rd <= 0) begin
          if (a_q == last_idx) begin
            a_d = '0;
            if (sw_q == sweeps_q - 16'd1) begin
              state_d = ST_E_RD;
            end else begin
              sw_d    = sw_q + 16'd1;
              state_d = ST_S_RD;
            end
          end else begin
            a_d     = a_q + 1'b1;
            state_d = ST_S_RD;
          end
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = qbit ? VALUE_W'(rem_sh - {2'b00, div_q}) : VALUE_W'(rem_sh);
        num_d = {num_q[NUM_W-2:0], 1'b0};
        quo_d = {quo_q[NUM_W-2:0], qbit};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        sol_we  = 1'b1;
        sol_wa  = a_q;
        sol_wd  = VALUE_W'(nx);
        dx_d    = DX_W'(nx) - DX_W'(x_q);
        b_d     = '0;
        state_d = ST_U_RD;
      end
      ST_U_RD: begin
        state_d = ST_U_MUL;
      end
      ST_U_MUL: begin
        prod_d  = PROD_W'(mat_rd) * PROD_W'(dx_q);
        state_d = ST_U_ACC;
      end
      ST_U_ACC: begin
        sum     = (GRAD_W+2)'(grad_rd) + (GRAD_W+2)'(floor_q16(prod_q));
        grad_we = 1'b1;
        grad_wd = sat_grad(sum);
        if (b_q == last_idx) begin
          if (a_q == last_idx) begin
            a_d = '0;
            if (sw_q == sweeps_q - 16'd1) begin
              state_d = ST_E_RD;
            end else begin
              sw_d    = sw_q + 16'd1;
              state_d = ST_S_RD;
            end
          end else begin
            a_d     = a_q + 1'b1;
            state_d = ST_S_RD;
          end
        end else begin
          b_d     = b_q + 1'b1;
          state_d = ST_U_RD;
        end
      end
      ST_E_RD: begin
        sol_ra  = a_q;
        state_d = ST_E_OUT;
      end
      ST_E_OUT: begin
        out_d.index    = 5'(a_q);
        out_d.solution = sol_rd;
        out_d.last     = (a_q == last_idx);
        out_valid_d    = 1'b1;
        state_d        = ST_E_WAIT;
      end
      ST_E_WAIT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (out_q.last) begin
            state_d = ST_IDLE;
          end else begin
            a_d     = a_q + 1'b1;
            state_d = ST_E_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      a_q         <= '0;
      b_q         <= '0;
      sw_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      size_q      <= 6'd32;
      sweeps_q    <= 16'd1;
    end else begin
      state_q     <= state_d;
      a_q         <= a_d;
      b_q         <= b_d;
      sw_q        <= sw_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_index_i == CFG_SIZE)) begin
        size_q <= cfg_data_i[5:0];
      end
      if (cfg_we_i && (cfg_index_i == CFG_SWEEPS)) begin
        sweeps_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
    x_q    <= x_d;
    div_q  <= div_d;
    neg_q  <= neg_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dx_q   <= dx_d;
    out_q  <= out_d;
  end

`ifndef SYNTHESIS
  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == ST_E_WAIT))
    else $error("output valid outside the emit wait state");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.last) |-> (a_q == last_idx))
    else $error("last flag on a non-final element");

  a_step_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> !sol_wd[VALUE_W-1])
    else $error("projected step wrote a negative value");

  a_grad_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grad_we |-> ((state_q == ST_I_ACC) || (state_q == ST_U_ACC)))
    else $error("gradient written outside an accumulate state");
`endif

endmodule

`default_nettype wire
